### rtl/lcd_serial_frame_parser_macros.svh
// Assertion macros for the serial frame parser.
// Needs nothing but the clock and reset names passed to each macro.
`ifndef LCD_SERIAL_FRAME_PARSER_MACROS_SVH
`define LCD_SERIAL_FRAME_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSFP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/lsfp_pkg.sv
// Constants shared by the serial frame parser.
// Has no dependencies.
`default_nettype none
package lsfp_pkg;

   localparam int BUF_BYTES = 64;

   localparam int KEEP_FIRST = 3;
   localparam int KEEP_COUNT = 6;

   localparam logic [7:0] HDR_FIRST  = 8'h5A;
   localparam logic [7:0] HDR_SECOND = 8'hA5;
   localparam logic [7:0] CMD_WRITE  = 8'h82;
   localparam logic [7:0] CMD_READ   = 8'h83;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam logic [7:0] MIN_WRITE_TOTAL = 8'd8;
   localparam logic [7:0] MIN_READ_TOTAL  = 8'd9;

endpackage
`default_nettype wire

### rtl/lcd_serial_frame_parser.sv
// Serial frame parser: finds headed frames in a byte stream and reports
// write notifications and read replies. Depends on lsfp_pkg and the macro header.
// A request is held in an input register and its result, if any, is registered
// into the response register when the held request advances, raising rsp_valid.
// Throughput: one request per cycle; req_stall rises only while the held request
// ends a frame with a result and an earlier result waits. Reset clears phase and valids.
`default_nettype none
`include "lcd_serial_frame_parser_macros.svh"
module lcd_serial_frame_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_frame_kind,
   output logic [15:0]      rsp_vp_address,
   output logic [15:0]      rsp_word_value
);
   import lsfp_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEAD,
      PH_LEN,
      PH_DATA
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  byte_index_ff, byte_index_in;
   logic [7:0]  frame_total_ff, frame_total_in;
   logic [7:0]  kept_ff [KEEP_COUNT];
   logic [7:0]  view [KEEP_COUNT];

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff, kind_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] word_ff, word_in;

   logic        accept;
   logic        advance;
   logic        emit;
   logic        keep_hit;
   logic [2:0]  keep_slot;
   logic [8:0]  len_sum;
   logic [8:0]  next_index;
   logic [7:0]  offset;

   always_comb begin
      offset    = byte_index_ff - 8'(KEEP_FIRST);
      keep_slot = offset[2:0];
      keep_hit  = (phase_ff == PH_DATA) && (byte_index_ff >= 8'(KEEP_FIRST))
                  && (offset < 8'(KEEP_COUNT));
      for (int j = 0; j < KEEP_COUNT; j++) begin
         view[j] = (keep_hit && keep_slot == 3'(j)) ? in_byte_ff : kept_ff[j];
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      byte_index_in  = byte_index_ff;
      frame_total_in = frame_total_ff;
      emit           = 1'b0;
      kind_in        = KIND_WRITE;
      addr_in        = {view[1], view[2]};
      word_in        = {view[3], view[4]};
      len_sum        = {1'b0, in_byte_ff} + 9'd3;
      next_index     = {1'b0, byte_index_ff} + 9'd1;
      unique case (phase_ff)
         PH_IDLE: begin
            if (in_byte_ff == HDR_FIRST) begin
               phase_in = PH_HEAD;
            end
         end
         PH_HEAD: begin
            if (in_byte_ff == HDR_SECOND) begin
               phase_in = PH_LEN;
            end else if (in_byte_ff == HDR_FIRST) begin
               phase_in = PH_HEAD;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_LEN: begin
            if (in_byte_ff == 8'd0 || len_sum > 9'(BUF_BYTES)) begin
               phase_in = PH_IDLE;
            end else begin
               frame_total_in = len_sum[7:0];
               byte_index_in  = 8'(KEEP_FIRST);
               phase_in       = PH_DATA;
            end
         end
         PH_DATA: begin
            byte_index_in = next_index[7:0];
            if (next_index >= {1'b0, frame_total_ff}) begin
               phase_in = PH_IDLE;
               if (view[0] == CMD_WRITE) begin
                  emit = (frame_total_ff >= MIN_WRITE_TOTAL);
               end else if (view[0] == CMD_READ) begin
                  emit    = (frame_total_ff >= MIN_READ_TOTAL) && (view[3] != 8'd0);
                  kind_in = KIND_READ;
                  word_in = {view[4], view[5]};
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   assign advance      = in_valid_ff && (!emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && emit) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         byte_index_ff  <= 8'd0;
         frame_total_ff <= 8'd0;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            in_byte_ff <= req_rx_byte;
         end
         if (advance) begin
            phase_ff       <= phase_in;
            byte_index_ff  <= byte_index_in;
            frame_total_ff <= frame_total_in;
            if (keep_hit) begin
               kept_ff[keep_slot] <= in_byte_ff;
            end
         end
         if (advance && emit) begin
            kind_ff <= kind_in;
            addr_ff <= addr_in;
            word_ff <= word_in;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_kind = kind_ff;
   assign rsp_vp_address = addr_ff;
   assign rsp_word_value = word_ff;

   `LSFP_ASSERT_IMPL(a_index_in_frame, clock, reset, phase_ff == PH_DATA,
      byte_index_ff < frame_total_ff, "byte index ran past the frame end")
   `LSFP_ASSERT_IMPL(a_total_in_buffer, clock, reset, phase_ff == PH_DATA,
      frame_total_ff <= 8'(BUF_BYTES) && frame_total_ff >= 8'd4,
      "frame total outside the buffer size")
   `LSFP_ASSERT_NEXT(a_held_request, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(in_byte_ff), "held request was lost or changed")
   `LSFP_ASSERT_IMPL(a_no_overwrite, clock, reset, advance && emit,
      !rsp_valid_ff || !rsp_stall, "result overwrote a waiting response")

endmodule
`default_nettype wire
